// ===== hdl/rcw_pkg.sv =====
package rcw_pkg;

  // Fixed field widths
  localparam int unsigned PnW   = 62;
  localparam int unsigned WinW  = 32;
  localparam int unsigned DivNW = 42;  // dividend width of the shared divider
  localparam int unsigned DivDW = 32;  // divisor width of the shared divider
  localparam int unsigned ProdW = 48;

  localparam logic [WinW-1:0] ALL32  = '1;
  localparam logic [PnW-1:0]  PN_ALL = '1;

  // Pacing modes
  localparam logic [1:0] MODE_SLOW     = 2'd0;
  localparam logic [1:0] MODE_JUMP     = 2'd1;
  localparam logic [1:0] MODE_RECOVERY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_INIT_WIN = 2'd0;
  localparam logic [1:0] REG_PAYLOAD  = 2'd1;
  localparam logic [1:0] REG_MIN_PKTS = 2'd2;
  localparam logic [1:0] REG_BETA     = 2'd3;

  typedef enum logic [1:0] {
    REQ_ACK     = 2'd0,
    REQ_LOSS    = 2'd1,
    REQ_JUMP    = 2'd2,
    REQ_RESTART = 2'd3
  } rcw_req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK1,
    S_ACK2,
    S_ACK3,
    S_ACK4,
    S_LOSS1,
    S_LRST,
    S_LOSS2,
    S_LOSS3,
    S_JUMP,
    S_RESTART,
    S_DIV,
    S_EMIT
  } rcw_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ACK1,
    OP_ACK2,
    OP_ACK3,
    OP_ACK4,
    OP_LOSS1,
    OP_LRST,
    OP_LOSS2,
    OP_LOSS3,
    OP_JUMP,
    OP_RESTART,
    OP_EMIT
  } rcw_op_e;

  typedef struct packed {
    rcw_op_e op;
  } rcw_cmd_t;

  typedef struct packed {
    logic below_rec;  // item number lies before the recovery end
    logic need_div;   // in avoidance, stash plus acked bytes reach one window
    logic restore;    // loss must restore the jumpstart window first
    logic div_busy;
    logic out_free;
  } rcw_sts_t;

  // Saturating 32-bit add
  function automatic logic [WinW-1:0] sat_add32(input logic [WinW-1:0] a,
                                                input logic [WinW-1:0] b);
    logic [WinW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WinW] ? ALL32 : s[WinW-1:0];
  endfunction

endpackage

// ===== hdl/rcw_div.sv =====
module rcw_div
  import rcw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic             busy_o,
  output logic [DivNW-1:0] quot_o,
  output logic [DivDW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DivNW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] dsr_q, dsr_d;
  logic [DivDW:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring form
  always_comb begin
    trial = {rem_q, quo_q[DivNW-1]};
    fits  = trial >= {1'b0, dsr_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    if (start_i) begin
      cnt_d = CntW'(DivNW);
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DivNW-2:0], fits};
      rem_d = fits ? DivDW'(trial - {1'b0, dsr_q}) : trial[DivDW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/rcw_ctrl.sv =====
module rcw_ctrl
  import rcw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  input  logic [1:0] s_axis_tuser,
  input  rcw_sts_t sts_i,
  output rcw_cmd_t cmd_o
);

  rcw_state_e state_q, state_d;
  rcw_req_e   req_q, req_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= REQ_ACK;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    cmd_o.op      = OP_NONE;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.op = OP_CAPTURE;
          req_d    = rcw_req_e'(s_axis_tuser);
          unique case (rcw_req_e'(s_axis_tuser))
            REQ_ACK:     state_d = S_ACK1;
            REQ_LOSS:    state_d = S_LOSS1;
            REQ_JUMP:    state_d = S_JUMP;
            REQ_RESTART: state_d = S_RESTART;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_ACK1: begin
        cmd_o.op = OP_ACK1;
        state_d  = sts_i.below_rec ? S_EMIT : S_ACK2;
      end
      S_ACK2: begin
        cmd_o.op = OP_ACK2;
        state_d  = sts_i.need_div ? S_DIV : S_EMIT;
      end
      S_ACK3: begin
        cmd_o.op = OP_ACK3;
        state_d  = S_ACK4;
      end
      S_ACK4: begin
        cmd_o.op = OP_ACK4;
        state_d  = S_EMIT;
      end
      S_LOSS1: begin
        cmd_o.op = OP_LOSS1;
        if (sts_i.below_rec) begin
          state_d = S_EMIT;
        end else if (sts_i.restore) begin
          state_d = S_DIV;
        end else begin
          state_d = S_LOSS2;
        end
      end
      S_LRST: begin
        cmd_o.op = OP_LRST;
        state_d  = S_LOSS2;
      end
      S_LOSS2: begin
        cmd_o.op = OP_LOSS2;
        state_d  = S_LOSS3;
      end
      S_LOSS3: begin
        cmd_o.op = OP_LOSS3;
        state_d  = S_EMIT;
      end
      S_JUMP: begin
        cmd_o.op = OP_JUMP;
        state_d  = S_EMIT;
      end
      S_RESTART: begin
        cmd_o.op = OP_RESTART;
        state_d  = S_EMIT;
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = (req_q == REQ_ACK) ? S_ACK3 : S_LRST;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTH
  // A divide that is started is seen as busy by the wait state.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ACK2 || state_q == S_LOSS1) && state_d == S_DIV) |=> sts_i.div_busy)
    else $error("divider not busy after start");

  // The divide result goes back to the branch of the item's kind.
  a_div_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !sts_i.div_busy) |=>
      ((req_q == REQ_ACK && state_q == S_ACK3) || (req_q == REQ_LOSS && state_q == S_LRST)))
    else $error("divide returned to wrong branch");

  // A result that goes out frees the block for the next item.
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && sts_i.out_free) |=> (state_q == S_IDLE))
    else $error("no return to idle after result");
`endif

endmodule

// ===== hdl/rcw_dp.sv =====
module rcw_dp
  import rcw_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rcw_cmd_t       cmd_i,
  output rcw_sts_t       sts_o,
  input  logic [31:0]    initial_window_i,
  input  logic [15:0]    payload_size_i,
  input  logic [7:0]     min_window_packets_i,
  input  logic [9:0]     beta_q10_i,
  input  logic [223:0]   s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [199:0]   m_axis_tdata
);

  localparam logic [WinW-1:0] InitWinRst = 32'd14720;

  // Captured item
  logic [WinW-1:0] bytes_q, infl_q, jw_q;
  logic [PnW-1:0]  pn_q, npn_q;

  // Connection state
  logic [WinW-1:0] cwnd_q, cwnd_d, ssth_q, ssth_d, jba_q, jba_d, stash_q, stash_d;
  logic [WinW-1:0] peak_q, peak_d, floor_q, floor_d, loss_q, loss_d, exitw_q, exitw_d;
  logic [PnW-1:0]  rec_q, rec_d, jent_q, jent_d, jexit_q, jexit_d;
  logic [1:0]      mode_q, mode_d;
  logic [ProdW-1:0] prod_q, prod_d;

  // Output register
  logic           ovalid_q, ovalid_d;
  logic [199:0]   odata_q, odata_d;

  // Divider interface
  logic             div_start, div_busy;
  logic [DivNW-1:0] div_n, div_quot;
  logic [DivDW-1:0] div_d, div_rem;

  logic [WinW-1:0]  stash_sum, beta_win, lvl;
  logic [9:0]       beta_eff;
  logic [23:0]      min_win;
  logic [ProdW:0]   grow_sum;

  assign beta_eff  = (beta_q10_i == '0) ? 10'd1 : beta_q10_i;
  assign min_win   = {16'b0, min_window_packets_i} * {8'b0, payload_size_i};
  assign stash_sum = sat_add32(stash_q, bytes_q);
  assign grow_sum  = {17'b0, cwnd_q} + {1'b0, prod_q};
  assign beta_win  = prod_q[41:10];

  // Status toward the controller
  assign sts_o.below_rec = pn_q < rec_q;
  assign sts_o.need_div  = !(cwnd_q < ssth_q) && !(stash_sum < cwnd_q) && (cwnd_q != '0);
  assign sts_o.restore   = (ssth_q == ALL32) && (pn_q < jexit_q);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !ovalid_q || m_axis_tready;

  // Divider start and operand selection
  always_comb begin
    div_start = 1'b0;
    div_n     = {jba_q, 10'b0};
    div_d     = {22'b0, beta_eff};
    if (cmd_i.op == OP_ACK2) begin
      div_start = sts_o.need_div;
      div_n     = {10'b0, stash_sum};
      div_d     = cwnd_q;
    end else if (cmd_i.op == OP_LOSS1) begin
      div_start = !sts_o.below_rec && sts_o.restore;
    end
  end

  rcw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // State updates per command
  always_comb begin
    cwnd_d  = cwnd_q;  ssth_d  = ssth_q;  jba_d   = jba_q;   stash_d = stash_q;
    peak_d  = peak_q;  floor_d = floor_q; loss_d  = loss_q;  exitw_d = exitw_q;
    rec_d   = rec_q;   jent_d  = jent_q;  jexit_d = jexit_q; mode_d  = mode_q;
    prod_d  = prod_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    lvl      = '0;
    unique case (cmd_i.op)
      OP_ACK1: begin
        if (sts_o.below_rec) begin
          if (pn_q < jexit_q) cwnd_d = sat_add32(cwnd_q, bytes_q);
        end else begin
          if (jent_q <= pn_q && pn_q < jexit_q) jba_d = sat_add32(jba_q, bytes_q);
          if (mode_q == MODE_JUMP && jent_q <= pn_q) begin
            cwnd_d  = infl_q;
            jexit_d = npn_q;
            mode_d  = MODE_SLOW;
          end
        end
      end
      OP_ACK2: begin
        if (cwnd_q < ssth_q) begin
          cwnd_d = sat_add32(cwnd_q, bytes_q);
          if (peak_q < cwnd_d) peak_d = cwnd_d;
        end else begin
          stash_d = stash_sum;
        end
      end
      OP_ACK3: prod_d = {16'b0, div_quot[31:0]} * {32'b0, payload_size_i};
      OP_ACK4: begin
        cwnd_d  = (grow_sum[ProdW:WinW] != '0) ? ALL32 : grow_sum[WinW-1:0];
        stash_d = div_rem;
        if (peak_q < cwnd_d) peak_d = cwnd_d;
      end
      OP_LOSS1: begin
        if (!sts_o.below_rec) begin
          rec_d  = npn_q;
          mode_d = MODE_RECOVERY;
          if (loss_q != ALL32) loss_d = loss_q + 1'b1;
        end
      end
      OP_LRST: cwnd_d = (div_quot[DivNW-1:WinW] != '0) ? ALL32 : div_quot[WinW-1:0];
      OP_LOSS2: begin
        if (exitw_q == '0) exitw_d = cwnd_q;
        prod_d = {16'b0, cwnd_q} * {38'b0, beta_eff};
      end
      OP_LOSS3: begin
        lvl    = (beta_win < {8'b0, min_win}) ? {8'b0, min_win} : beta_win;
        cwnd_d = lvl;
        ssth_d = lvl;
        if (floor_q > lvl) floor_d = lvl;
      end
      OP_JUMP: begin
        if ({1'b0, cwnd_q, 1'b0} < {1'b0, 1'b0, jw_q}) begin
          jent_d = npn_q;
          cwnd_d = jw_q;
          mode_d = MODE_JUMP;
        end
      end
      OP_RESTART: begin
        cwnd_d  = initial_window_i; ssth_d  = ALL32;  rec_d   = '0;
        jent_d  = PN_ALL;           jexit_d = '0;     jba_d   = '0;
        stash_d = '0;               peak_d  = initial_window_i;
        floor_d = ALL32;            loss_d  = '0;     exitw_d = '0;
        mode_d  = MODE_SLOW;
      end
      OP_EMIT: begin
        ovalid_d = 1'b1;
        odata_d  = {6'b0, exitw_q, loss_q, floor_q, peak_q, mode_q, ssth_q, cwnd_q};
      end
      OP_NONE, OP_CAPTURE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwnd_q   <= InitWinRst; ssth_q  <= ALL32;  rec_q   <= '0;
      jent_q   <= PN_ALL;     jexit_q <= '0;     jba_q   <= '0;
      stash_q  <= '0;         peak_q  <= InitWinRst;
      floor_q  <= ALL32;      loss_q  <= '0;     exitw_q <= '0;
      mode_q   <= MODE_SLOW;  ovalid_q <= 1'b0;
    end else begin
      cwnd_q   <= cwnd_d;  ssth_q  <= ssth_d;  rec_q   <= rec_d;
      jent_q   <= jent_d;  jexit_q <= jexit_d; jba_q   <= jba_d;
      stash_q  <= stash_d; peak_q  <= peak_d;
      floor_q  <= floor_d; loss_q  <= loss_d;  exitw_q <= exitw_d;
      mode_q   <= mode_d;  ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    odata_q <= odata_d;
    if (cmd_i.op == OP_CAPTURE) begin
      bytes_q <= s_axis_tdata[31:0];
      pn_q    <= s_axis_tdata[93:32];
      infl_q  <= s_axis_tdata[125:94];
      npn_q   <= s_axis_tdata[187:126];
      jw_q    <= s_axis_tdata[219:188];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

// ===== hdl/reno_congestion_window_unit.sv =====
// Jumpstart, restart and acks or losses before the recovery end go straight to the
// result; other acks that do not drain the stash take a second ack step, a loss that
// needs no restore takes the backoff multiply and level steps, and an ack that drains
// the stash or a loss that restores the window also waits on the shared 42-step radix-2
// divider. One item is worked on at a time; the next item is taken while a result waits.
// Reset is asynchronous and active low and loads defaults.
module reno_congestion_window_unit
  import rcw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // event_bytes[31:0], packet_number[93:32], bytes_in_flight[125:94],
  // next_packet_number[187:126], jump_window[219:188], zero fill
  input  logic [223:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  // Result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // window[31:0], threshold[63:32], pacing_mode[65:64], window_peak[97:66],
  // window_floor[129:98], loss_episodes[161:130], window_at_exit[193:162], zero fill
  output logic [199:0] m_axis_tdata,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0] init_win_q;
  logic [15:0] payload_q;
  logic [7:0]  min_pkts_q;
  logic [9:0]  beta_q;
  logic        cfg_wr;
  rcw_cmd_t    cmd;
  rcw_sts_t    sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_win_q <= 32'd14720;
      payload_q  <= 16'd1472;
      min_pkts_q <= 8'd2;
      beta_q     <= 10'd717;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_INIT_WIN: init_win_q <= pwdata;
        REG_PAYLOAD:  payload_q  <= pwdata[15:0];
        REG_MIN_PKTS: min_pkts_q <= pwdata[7:0];
        REG_BETA:     beta_q     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[3:2])
      REG_INIT_WIN: prdata = init_win_q;
      REG_PAYLOAD:  prdata = {16'b0, payload_q};
      REG_MIN_PKTS: prdata = {24'b0, min_pkts_q};
      REG_BETA:     prdata = {22'b0, beta_q};
      default:      prdata = '0;
    endcase
  end

  rcw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rcw_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .initial_window_i     (init_win_q),
    .payload_size_i       (payload_q),
    .min_window_packets_i (min_pkts_q),
    .beta_q10_i           (beta_q),
    .s_axis_tdata         (s_axis_tdata),
    .m_axis_tvalid        (m_axis_tvalid),
    .m_axis_tready        (m_axis_tready),
    .m_axis_tdata         (m_axis_tdata)
  );

endmodule
